// ===== rtl/core/epr_pkg.sv =====
package epr_pkg;

  // Default sizes
  localparam int SLOTS_DEF        = 64;
  localparam int BUCKET_DEPTH_DEF = 32;
  localparam int PHASES           = 3;

  // Request operation codes
  typedef enum logic [2:0] {
    FN_REGISTER   = 3'd0,
    FN_UNREGISTER = 3'd1,
    FN_PIN        = 3'd2,
    FN_UNPIN      = 3'd3,
    FN_RETIRE     = 3'd4,
    FN_RECLAIM    = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_BLOCKED = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_DRAIN = 2'd2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic drain;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic needs_drain;
    logic drain_done;
  } stat_t;

endpackage

// ===== rtl/core/epr_ctrl.sv =====
module epr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output epr_pkg::cmd_t  cmd,
  input  epr_pkg::stat_t stat
);
  import epr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = stat.needs_drain ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (stat.drain_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/epr_dp.sv =====
module epr_dp #(
  parameter int SLOTS        = epr_pkg::SLOTS_DEF,
  parameter int BUCKET_DEPTH = epr_pkg::BUCKET_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  epr_pkg::cmd_t  cmd,
  output epr_pkg::stat_t stat,
  input  logic [2:0]     in_func,
  input  logic [5:0]     in_slot,
  input  logic [31:0]    in_handle,
  input  logic [15:0]    in_tag,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [5:0]     out_slot,
  output logic           out_handle_valid,
  output logic [31:0]    out_handle,
  output logic [15:0]    out_tag,
  output logic [5:0]     out_count,
  output logic           out_last
);
  import epr_pkg::*;

  localparam int SW    = $clog2(SLOTS);
  localparam int NGRP  = (SLOTS + 7) / 8;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int DEPTH = PHASES * BUCKET_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [PHASES-1:0] PH_ONE = PHASES'(1);

  // lowest set bit of a byte
  function automatic logic [2:0] low8(input logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Request registers
  func_t       req_func;
  logic [5:0]  req_slot;
  logic [31:0] req_handle;
  logic [15:0] req_tag;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func   <= func_t'(in_func);
      req_slot   <= in_slot;
      req_handle <= in_handle;
      req_tag    <= in_tag;
    end
  end

  logic          req_in_range;
  logic [SW-1:0] req_idx;
  assign req_in_range = 32'(req_slot) < SLOTS;
  assign req_idx      = SW'(req_slot);

  // Slot table: flags in flops, pin phase in a small memory
  logic [SLOTS-1:0] active, active_next;
  logic [SLOTS-1:0] pinned, pinned_next;
  logic [1:0]       phase_mem [SLOTS];
  logic [1:0]       phase_q;
  logic             pm_we;
  logic [SW-1:0]    pm_addr;

  // Per-phase count of active, pinned slots at that phase
  logic [CW-1:0]     cnt [PHASES];
  logic [PHASES-1:0] inc, dec;

  // Epoch phase and bucket fills
  logic [1:0]    ph, ph_next;
  logic [FW-1:0] fill [PHASES];
  logic [FW-1:0] cur_fill;
  logic [AW-1:0] base_cur;
  logic          blocked;
  logic          fill_clr, fill_inc, ph_adv;

  assign ph_next  = (32'(ph) == PHASES - 1) ? 2'd0 : ph + 2'd1;
  assign cur_fill = fill[ph];
  assign base_cur = AW'(32'(ph) * BUCKET_DEPTH);
  assign blocked  = cnt[ph] != '0;

  // Free-slot search, first level registered per group of eight
  logic [NGRP*8-1:0] free_pad;
  logic [NGRP-1:0]   grp_free_q;
  logic [2:0]        grp_idx_q [NGRP];
  logic              found;
  logic [SW-1:0]     fs;

  always_comb begin
    free_pad = '0;
    free_pad[SLOTS-1:0] = ~active;
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_q[g] <= |free_pad[g*8 +: 8];
      grp_idx_q[g]  <= low8(free_pad[g*8 +: 8]);
    end
  end

  // Second level: first group with a free slot
  always_comb begin
    found = 1'b0;
    fs    = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (!found && grp_free_q[g]) begin
        found = 1'b1;
        fs    = SW'(32'(g) * 8 + 32'(grp_idx_q[g]));
      end
    end
  end

  // Bucket memory and drain bookkeeping
  logic [47:0]   bk_mem [DEPTH];
  logic [47:0]   rd_q;
  logic          bk_we;
  logic [AW-1:0] bk_addr, rd_addr;
  logic          rd_full;
  logic [AW-1:0] drain_base;
  logic [IW-1:0] issue_idx;
  logic [FW-1:0] issue_left, emit_left, drain_total;
  logic          drain_start, d_load, d_issue, out_free;

  assign out_free = !out_valid || out_ready;
  assign d_load   = cmd.drain && rd_full && out_free;
  assign d_issue  = cmd.drain && (issue_left != '0) && (!rd_full || d_load);
  assign rd_addr  = drain_base + AW'(issue_idx);
  assign bk_addr  = base_cur + AW'(cur_fill);

  // Single-result load
  logic        ld, ld_hv;
  status_t     ld_status;
  logic [5:0]  ld_slot;
  logic [31:0] ld_h;
  logic [15:0] ld_t;
  logic        old_pin;

  assign old_pin = req_in_range && active[req_idx] && pinned[req_idx];

  // Operation execute
  always_comb begin
    active_next = active;
    pinned_next = pinned;
    inc         = '0;
    dec         = '0;
    pm_we       = 1'b0;
    pm_addr     = req_idx;
    bk_we       = 1'b0;
    fill_clr    = 1'b0;
    fill_inc    = 1'b0;
    ph_adv      = 1'b0;
    drain_start = 1'b0;
    ld          = 1'b0;
    ld_status   = ST_OK;
    ld_slot     = '0;
    ld_hv       = 1'b0;
    ld_h        = '0;
    ld_t        = '0;
    if (cmd.exec) begin
      ld = 1'b1;
      case (req_func)
        FN_REGISTER: begin
          if (found) begin
            active_next[fs] = 1'b1;
            pinned_next[fs] = 1'b1;
            pm_we           = 1'b1;
            pm_addr         = fs;
            inc             = PH_ONE << ph;
            ld_slot         = 6'(fs);
          end else begin
            ld_status = ST_NO_SLOT;
          end
        end
        FN_UNREGISTER: begin
          if (req_in_range) begin
            active_next[req_idx] = 1'b0;
            pinned_next[req_idx] = 1'b0;
            if (old_pin) dec = PH_ONE << phase_q;
          end
        end
        FN_PIN: begin
          if (req_in_range) begin
            pinned_next[req_idx] = 1'b1;
            pm_we                = 1'b1;
            if (old_pin) dec = PH_ONE << phase_q;
            if (active[req_idx]) inc = PH_ONE << ph;
          end
        end
        FN_UNPIN: begin
          if (req_in_range) begin
            pinned_next[req_idx] = 1'b0;
            if (old_pin) dec = PH_ONE << phase_q;
          end
        end
        FN_RETIRE: begin
          if (req_handle != '0) begin
            if (32'(cur_fill) >= BUCKET_DEPTH) begin
              // bucket full: hand it straight back
              ld_hv = 1'b1;
              ld_h  = req_handle;
              ld_t  = req_tag;
            end else begin
              bk_we    = 1'b1;
              fill_inc = 1'b1;
            end
          end
        end
        FN_RECLAIM: begin
          if (blocked) begin
            ld_status = ST_BLOCKED;
          end else begin
            fill_clr = 1'b1;
            ph_adv   = 1'b1;
            if (cur_fill != '0) begin
              ld          = 1'b0;
              drain_start = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot flags and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      pinned <= '0;
      for (int p = 0; p < PHASES; p++) cnt[p] <= '0;
    end else begin
      active <= active_next;
      pinned <= pinned_next;
      for (int p = 0; p < PHASES; p++) begin
        cnt[p] <= cnt[p] + CW'(inc[p]) - CW'(dec[p]);
      end
    end
  end

  // Pin phase memory
  always_ff @(posedge clk) begin
    if (pm_we) phase_mem[pm_addr] <= ph;
    if (cmd.load_req) phase_q <= phase_mem[SW'(in_slot)];
  end

  // Phase and fills
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= '0;
      for (int p = 0; p < PHASES; p++) fill[p] <= '0;
    end else begin
      if (fill_clr) begin
        fill[ph] <= '0;
      end else if (fill_inc) begin
        fill[ph] <= cur_fill + FW'(1);
      end
      if (ph_adv) ph <= ph_next;
    end
  end

  // Bucket memory
  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_addr] <= {req_tag, req_handle};
    if (d_issue) rd_q <= bk_mem[rd_addr];
  end

  // Drain counters, newest entry first
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_full    <= 1'b0;
      issue_left <= '0;
      emit_left  <= '0;
    end else if (drain_start) begin
      rd_full    <= 1'b0;
      issue_left <= cur_fill;
      emit_left  <= cur_fill;
    end else begin
      if (d_issue) begin
        rd_full    <= 1'b1;
        issue_left <= issue_left - FW'(1);
      end else if (d_load) begin
        rd_full <= 1'b0;
      end
      if (d_load) emit_left <= emit_left - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (drain_start) begin
      drain_base  <= base_cur;
      drain_total <= cur_fill;
      issue_idx   <= IW'(cur_fill - FW'(1));
    end else if (d_issue) begin
      issue_idx <= issue_idx - IW'(1);
    end
  end

  // Output register
  logic d_last;
  assign d_last = emit_left == FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld || d_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load) begin
      out_status       <= ST_OK;
      out_slot         <= '0;
      out_handle_valid <= 1'b1;
      out_handle       <= rd_q[31:0];
      out_tag          <= rd_q[47:32];
      out_count        <= d_last ? 6'(drain_total) : 6'd0;
      out_last         <= d_last;
    end else if (ld) begin
      out_status       <= ld_status;
      out_slot         <= ld_slot;
      out_handle_valid <= ld_hv;
      out_handle       <= ld_h;
      out_tag          <= ld_t;
      out_count        <= '0;
      out_last         <= 1'b1;
    end
  end

  // Status to controller
  assign stat.out_free    = out_free;
  assign stat.needs_drain = (req_func == FN_RECLAIM) && !blocked && (cur_fill != '0);
  assign stat.drain_done  = d_load && d_last;

  // Checks
  a_drain_balance: assert property (@(posedge clk) disable iff (rst)
    emit_left == issue_left + FW'(rd_full))
    else $error("drain issue and emit counts out of step");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cur_fill) <= BUCKET_DEPTH)
    else $error("bucket fill beyond depth");

  a_pin_total: assert property (@(posedge clk) disable iff (rst)
    32'(cnt[0]) + 32'(cnt[1]) + 32'(cnt[2]) <= SLOTS)
    else $error("pinned slot count exceeds table size");

  a_exec_room: assert property (@(posedge clk) disable iff (rst)
    (ld || d_load) |-> out_free)
    else $error("output register overwritten");

endmodule

// ===== rtl/core/epoch_reclaim_tracker.sv =====
// A single-result request is held in the request registers once accepted, executed once the
// output register has room, and its result is registered onto m_tdata. No new request is taken
// until the last has executed. A reclaim of n stored handles streams them one per cycle, while
// the output is taken, from the bucket memory read port before the next request is accepted.
// Reset (rst, synchronous): slot flags, pin counters, epoch phase and bucket fills clear at
// once; bucket and pin-phase memories are not cleared and need no clearing pass.
module epoch_reclaim_tracker #(
  parameter int SLOTS        = epr_pkg::SLOTS_DEF,
  parameter int BUCKET_DEPTH = epr_pkg::BUCKET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // slot[5:0], handle[37:6], free_tag[53:38], zero pad
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // status[1:0], grant_slot[7:2], freed_handle[39:8],
                                 // freed_tag[55:40], freed_count[61:56], zero pad
  output logic [0:0]  m_tuser,   // handle_valid[0]
  output logic        m_tlast
);
  import epr_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  o_status;
  logic [5:0]  o_slot;
  logic        o_hv;
  logic [31:0] o_handle;
  logic [15:0] o_tag;
  logic [5:0]  o_count;

  epr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  epr_dp #(
    .SLOTS        (SLOTS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (s_tuser),
    .in_slot          (s_tdata[5:0]),
    .in_handle        (s_tdata[37:6]),
    .in_tag           (s_tdata[53:38]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_status       (o_status),
    .out_slot         (o_slot),
    .out_handle_valid (o_hv),
    .out_handle       (o_handle),
    .out_tag          (o_tag),
    .out_count        (o_count),
    .out_last         (m_tlast)
  );

  // Result packing
  assign m_tdata    = {2'b00, o_count, o_tag, o_handle, o_slot, o_status};
  assign m_tuser[0] = o_hv;

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epr_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int BUCKET_DEPTH = BUCKET_DEPTH_DEF;

  // Codes the block accepts but does nothing with
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 110;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT   = 4000;
  localparam int REPORT_CAP   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;    // slot[5:0], handle[37:6], free_tag[53:38], zero pad
  logic [2:0]  s_tuser = '0;    // func[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // status[1:0], grant_slot[7:2], freed_handle[39:8],
                                // freed_tag[55:40], freed_count[61:56], zero pad
  logic [0:0]  m_tuser;         // handle_valid[0]
  logic        m_tlast;

  // One result as the block reports it
  typedef struct {
    status_t     status;
    logic [5:0]  grant_slot;
    logic        handle_valid;
    logic [31:0] freed_handle;
    logic [15:0] freed_tag;
    logic [5:0]  freed_count;
    logic        last;
  } epoch_result_t;

  // Tracks slot table, phase and buckets; queues the results each request causes
  class reclaim_scoreboard;
    bit          active [SLOTS];
    bit          pinned [SLOTS];
    bit [1:0]    pin_phase [SLOTS];
    bit [1:0]    phase;
    bit [31:0]   bucket_h [PHASES][BUCKET_DEPTH];
    bit [15:0]   bucket_tag [PHASES][BUCKET_DEPTH];
    int          fill [PHASES];
    epoch_result_t expected_q [$];
    int          errors;

    function int pending();
      return expected_q.size();
    endfunction

    function int lowest_free();
      for (int i = 0; i < SLOTS; i++)
        if (!active[i]) return i;
      return -1;
    endfunction

    function void note_request(logic [2:0] fn, logic [5:0] sl, logic [31:0] h,
                               logic [15:0] tg);
      epoch_result_t r;
      int n;
      bit hit;
      r = '{ST_OK, 6'd0, 1'b0, 32'd0, 16'd0, 6'd0, 1'b1};
      case (fn)
        FN_REGISTER: begin
          n = lowest_free();
          if (n < 0) begin
            r.status = ST_NO_SLOT;
          end else begin
            active[n]    = 1'b1;
            pinned[n]    = 1'b1;
            pin_phase[n] = phase;
            r.grant_slot = 6'(n);
          end
          expected_q.push_back(r);
        end
        FN_UNREGISTER: begin
          active[sl] = 1'b0;
          pinned[sl] = 1'b0;
          expected_q.push_back(r);
        end
        FN_PIN: begin
          pinned[sl]    = 1'b1;
          pin_phase[sl] = phase;
          expected_q.push_back(r);
        end
        FN_UNPIN: begin
          pinned[sl] = 1'b0;
          expected_q.push_back(r);
        end
        FN_RETIRE: begin
          // null is dropped; a full bucket hands the handle straight back
          if (h != '0) begin
            if (fill[phase] >= BUCKET_DEPTH) begin
              r.handle_valid = 1'b1;
              r.freed_handle = h;
              r.freed_tag    = tg;
            end else begin
              bucket_h[phase][fill[phase]]   = h;
              bucket_tag[phase][fill[phase]] = tg;
              fill[phase]++;
            end
          end
          expected_q.push_back(r);
        end
        FN_RECLAIM: begin
          hit = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (active[i] && pinned[i] && pin_phase[i] == phase) hit = 1'b1;
          if (hit) begin
            r.status = ST_BLOCKED;
            expected_q.push_back(r);
          end else begin
            n = fill[phase];
            fill[phase] = 0;
            if (n == 0) expected_q.push_back(r);
            // newest first; count rides on the last one
            for (int k = n - 1; k >= 0; k--) begin
              r.handle_valid = 1'b1;
              r.freed_handle = bucket_h[phase][k];
              r.freed_tag    = bucket_tag[phase][k];
              r.last         = (k == 0);
              r.freed_count  = (k == 0) ? 6'(n) : 6'd0;
              expected_q.push_back(r);
            end
            phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          end
        end
        default: expected_q.push_back(r);
      endcase
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] want_v);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch: %s got 0x%0h expected 0x%0h (%0d still due)",
                 what, got_v, want_v, expected_q.size());
    endtask

    task check_result(epoch_result_t got);
      epoch_result_t want;
      if (expected_q.size() == 0) begin
        report("result with nothing outstanding, handle", got.freed_handle, 32'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.grant_slot !== want.grant_slot)
        report("grant_slot", 32'(got.grant_slot), 32'(want.grant_slot));
      if (got.handle_valid !== want.handle_valid)
        report("handle_valid", 32'(got.handle_valid), 32'(want.handle_valid));
      if (got.freed_handle !== want.freed_handle)
        report("freed_handle", got.freed_handle, want.freed_handle);
      if (got.freed_tag !== want.freed_tag)
        report("freed_tag", 32'(got.freed_tag), 32'(want.freed_tag));
      if (got.freed_count !== want.freed_count)
        report("freed_count", 32'(got.freed_count), 32'(want.freed_count));
      if (got.last !== want.last)
        report("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  reclaim_scoreboard sb;
  int burst_left = 0;
  int items = 0;
  int hold_reqs = 0;

  epoch_reclaim_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rand_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request, with a random gap whenever the current burst runs out
  task automatic send_req(input logic [2:0] fn, input logic [5:0] sl,
                          input logic [31:0] h, input logic [15:0] tg);
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {2'b00, tg, h, sl};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request(fn, sl, h, tg);
    burst_left--;
    if (!(fn == FN_RETIRE && h == '0) && fn <= FN_RECLAIM) items++;
  endtask

  // Reader lifecycle: register, retire a few, then unregister, unpin or leave the slot pinned, reclaim
  task automatic run_session();
    int s;
    s = sb.lowest_free();
    send_req(FN_REGISTER, 6'($urandom), rand_handle(), 16'($urandom));
    if (s < 0) return;
    repeat ($urandom_range(0, 6))
      send_req(FN_RETIRE, 6'($urandom), rand_handle(), 16'($urandom));
    case ($urandom_range(0, 3))
      0: send_req(FN_UNREGISTER, 6'(s), rand_handle(), 16'($urandom));
      1: begin
        send_req(FN_PIN, 6'(s), rand_handle(), 16'($urandom));
        send_req(FN_UNPIN, 6'(s), rand_handle(), 16'($urandom));
      end
      2: send_req(FN_UNPIN, 6'(s), rand_handle(), 16'($urandom));
      default: ;  // leave it pinned so a later reclaim may be refused
    endcase
    send_req(FN_RECLAIM, 6'($urandom), rand_handle(), 16'($urandom));
  endtask

  // Main stimulus
  initial begin
    int base;
    bit held;
    bit paused;
    sb = new;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every code, refused and empty reclaims
    send_req(FN_REGISTER, 6'd0, 32'd0, 16'd0);
    send_req(FN_REGISTER, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(FN_RETIRE, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(FN_RETIRE, 6'd0, 32'd0, 16'h1234);
    send_req(FN_RETIRE, 6'd0, 32'd1, 16'd0);
    send_req(FN_RECLAIM, 6'd0, 32'd0, 16'd0);
    send_req(FN_UNPIN, 6'd0, 32'd0, 16'd0);
    send_req(FN_PIN, 6'd63, 32'd0, 16'd0);
    send_req(FN_UNREGISTER, 6'd1, 32'd0, 16'd0);
    send_req(FN_RECLAIM, 6'd0, 32'd0, 16'd0);
    send_req(FN_RECLAIM, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(FN_PIN, 6'd0, 32'd0, 16'd0);
    send_req(FN_RECLAIM, 6'd0, 32'd0, 16'd0);
    send_req(FN_UNPIN, 6'd63, 32'd0, 16'd0);
    send_req(FN_SPARE_A, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(FN_SPARE_B, 6'd0, 32'd0, 16'd0);
    send_req(FN_REGISTER, 6'd0, 32'd0, 16'd0);
    send_req(FN_UNREGISTER, 6'd0, 32'd0, 16'd0);
    send_req(FN_UNREGISTER, 6'd1, 32'd0, 16'd0);
    send_req(FN_RECLAIM, 6'd0, 32'd0, 16'd0);
    send_req(FN_RETIRE, 6'd21, 32'hA5A5_5A5A, 16'h5AA5);
    send_req(FN_RECLAIM, 6'd42, 32'd0, 16'd0);

    // fill the slot table until register is refused, then empty it again
    while (sb.lowest_free() >= 0)
      send_req(FN_REGISTER, 6'($urandom), rand_handle(), 16'($urandom));
    send_req(FN_REGISTER, 6'($urandom), rand_handle(), 16'($urandom));
    send_req(FN_RECLAIM, 6'($urandom), rand_handle(), 16'($urandom));
    for (int i = 0; i < SLOTS; i++)
      send_req(FN_UNREGISTER, 6'(i), rand_handle(), 16'($urandom));

    // fill the current bucket, overflow it, then drain a full bucket
    while (sb.fill[sb.phase] < BUCKET_DEPTH)
      send_req(FN_RETIRE, 6'($urandom), $urandom | 32'd1, 16'($urandom));
    repeat (2) send_req(FN_RETIRE, 6'($urandom), $urandom | 32'd1, 16'($urandom));
    send_req(FN_RECLAIM, 6'($urandom), rand_handle(), 16'($urandom));

    // random mix, mostly reader sessions
    base = items;
    while (items < base + RANDOM_ITEMS) begin
      if (!held && items >= base + 30) begin
        // output blocked for a long stretch while requests keep coming
        held = 1'b1;
        hold_reqs++;
        burst_left = 20;
      end
      if (!paused && items >= base + 70) begin
        // let every outstanding result come back before going on
        paused = 1'b1;
        burst_left = 0;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_session();
        6, 7: send_req(3'($urandom), 6'($urandom), rand_handle(), 16'($urandom));
        8: send_req(FN_RECLAIM, 6'($urandom), rand_handle(), 16'($urandom));
        default: send_req($urandom_range(0, 1) ? FN_PIN : FN_UNPIN, 6'($urandom_range(0, 7)),
                          rand_handle(), 16'($urandom));
      endcase
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  // Result side: check each accepted result, stall on a changing pattern
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    epoch_result_t got;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        got.status       = status_t'(m_tdata[1:0]);
        got.grant_slot   = m_tdata[7:2];
        got.freed_handle = m_tdata[39:8];
        got.freed_tag    = m_tdata[55:40];
        got.freed_count  = m_tdata[61:56];
        got.handle_valid = m_tuser[0];
        got.last         = m_tlast;
        sb.check_result(got);
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== epoch_reclaim_tracker.f =====
rtl/core/epr_pkg.sv
rtl/core/epr_ctrl.sv
rtl/core/epr_dp.sv
rtl/core/epoch_reclaim_tracker.sv
bench/tb.sv
